// ===== rtl/core/crt_pkg.sv =====
// Shared types, codes and helper functions for the credit and rating table.
`timescale 1ns / 1ps

package crt_pkg;

  // Fixed widths of the payload fields.
  localparam int ADDR_W   = 16;
  localparam int VALUE_W  = 16;
  localparam int CREDIT_W = 16;
  localparam int STEP_W   = 15;
  localparam int RATING_W = 8;
  localparam int OP_W     = 4;
  localparam int CFG_IDX_W = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD        = 4'd0;
  localparam logic [OP_W-1:0] OP_REMOVE     = 4'd1;
  localparam logic [OP_W-1:0] OP_CREDIT_UP  = 4'd2;
  localparam logic [OP_W-1:0] OP_CREDIT_DN  = 4'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 4'd4;
  localparam logic [OP_W-1:0] OP_CREDIT_ALL = 4'd5;
  localparam logic [OP_W-1:0] OP_RATING_SET = 4'd6;
  localparam logic [OP_W-1:0] OP_RATING_UP  = 4'd7;
  localparam logic [OP_W-1:0] OP_RATING_DN  = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CREDIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CREDIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_CREDIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_UP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_RATING   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GOOD_RATING    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAULTY_RATING  = 3'd7;

  // Reset values of the configuration registers.
  localparam logic signed [CREDIT_W-1:0] RST_MAX_CREDIT     = 16'sd100;
  localparam logic signed [CREDIT_W-1:0] RST_MIN_CREDIT     = 16'sd0;
  localparam logic signed [CREDIT_W-1:0] RST_INITIAL_CREDIT = 16'sd10;
  localparam logic [STEP_W-1:0]          RST_STEP_UP        = 15'd1;
  localparam logic [STEP_W-1:0]          RST_STEP_DOWN      = 15'd1;
  localparam logic signed [RATING_W-1:0] RST_START_RATING   = 8'sd0;
  localparam logic signed [RATING_W-1:0] RST_GOOD_RATING    = 8'sd10;
  localparam logic signed [RATING_W-1:0] RST_FAULTY_RATING  = -8'sd10;

  // Values reported for an address that is not in the table.
  localparam logic signed [CREDIT_W-1:0] CREDIT_ABSENT = -16'sd1;
  localparam logic signed [RATING_W-1:0] RATING_ABSENT = 8'sd0;

  // Saturation bounds on a 17-bit intermediate.
  localparam logic signed [CREDIT_W:0] CREDIT_LO = -17'sd32768;
  localparam logic signed [CREDIT_W:0] CREDIT_HI = 17'sd32767;
  localparam logic signed [CREDIT_W:0] RATING_LO = -17'sd128;
  localparam logic signed [CREDIT_W:0] RATING_HI = 17'sd127;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [ADDR_W-1:0]        address;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                      ok;
    logic                      present;
    logic signed [CREDIT_W-1:0] credit;
    logic signed [RATING_W-1:0] rating;
  } rsp_t;

  typedef struct packed {
    logic signed [CREDIT_W-1:0] max_credit;
    logic signed [CREDIT_W-1:0] min_credit;
    logic signed [CREDIT_W-1:0] initial_credit;
    logic [STEP_W-1:0]          step_up;
    logic [STEP_W-1:0]          step_down;
    logic signed [RATING_W-1:0] start_rating;
    logic signed [RATING_W-1:0] good_rating;
    logic signed [RATING_W-1:0] faulty_rating;
  } cfg_t;

  // The command that walks down the row of cells, with what it has gathered.
  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic signed [VALUE_W-1:0]  value;
    logic                       found;
    logic                       ok;
    logic                       free_seen;
    logic signed [CREDIT_W-1:0] credit;
    logic signed [RATING_W-1:0] rating;
  } tok_t;

  // Saturate a 17-bit sum to the signed credit range.
  function automatic logic signed [CREDIT_W-1:0] sat_credit(input logic signed [CREDIT_W:0] v);
    logic signed [CREDIT_W-1:0] r;
    if (v < CREDIT_LO) begin
      r = CREDIT_LO[CREDIT_W-1:0];
    end else if (v > CREDIT_HI) begin
      r = CREDIT_HI[CREDIT_W-1:0];
    end else begin
      r = v[CREDIT_W-1:0];
    end
    return r;
  endfunction

  // Saturate a 17-bit sum to the signed rating range.
  function automatic logic signed [RATING_W-1:0] sat_rating(input logic signed [CREDIT_W:0] v);
    logic signed [RATING_W-1:0] r;
    if (v < RATING_LO) begin
      r = RATING_LO[RATING_W-1:0];
    end else if (v > RATING_HI) begin
      r = RATING_HI[RATING_W-1:0];
    end else begin
      r = v[RATING_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/crt_cell.sv =====
// One table slot: holds an entry and applies the passing command to it.
`timescale 1ns / 1ps

module crt_cell import crt_pkg::*; #(
  parameter int IDX_W  = 4,
  parameter int KEY_W  = 16,
  parameter int MY_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             tok_in_valid,
  input  tok_t             tok_in,
  input  logic [KEY_W-1:0] key_in,
  input  logic [IDX_W-1:0] free_idx_in,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [KEY_W-1:0] wr_key,
  output logic             tok_out_valid,
  output tok_t             tok_out,
  output logic [KEY_W-1:0] key_out,
  output logic [IDX_W-1:0] free_idx_out
);

  logic                       valid, valid_next;
  logic [KEY_W-1:0]           key, key_next;
  logic signed [CREDIT_W-1:0] credit, credit_next;
  logic signed [RATING_W-1:0] rating, rating_next;
  tok_t                       tok_next;
  logic [IDX_W-1:0]           free_idx_next;

  logic                       hit;
  logic signed [CREDIT_W:0]   c_ext, v_ext, r_ext;
  logic signed [CREDIT_W:0]   c_up, c_dn, c_all, r_up, r_dn;

  // Wide operands for the bound checks.
  assign c_ext = {credit[CREDIT_W-1], credit};
  assign v_ext = {tok_in.value[VALUE_W-1], tok_in.value};
  assign r_ext = {{(CREDIT_W + 1 - RATING_W){rating[RATING_W-1]}}, rating};
  assign c_up  = c_ext + $signed({2'b00, cfg.step_up});
  assign c_dn  = c_ext - $signed({2'b00, cfg.step_down});
  assign c_all = c_ext + v_ext;
  assign r_up  = r_ext + v_ext;
  assign r_dn  = r_ext - v_ext;

  assign hit = tok_in_valid && valid && (key == key_in);

  // Entry update and command hand-off.
  always_comb begin
    valid_next    = valid;
    key_next      = key;
    credit_next   = credit;
    rating_next   = rating;
    tok_next      = tok_in;
    free_idx_next = free_idx_in;

    if (wr_en && (wr_idx == IDX_W'(MY_IDX))) begin
      // A new entry lands here after a sweep found no match.
      valid_next  = 1'b1;
      key_next    = wr_key;
      credit_next = cfg.initial_credit;
      rating_next = cfg.start_rating;
    end else if (tok_in_valid) begin
      // The first empty slot along the row is the one an add would take.
      if (!tok_in.free_seen && !valid) begin
        tok_next.free_seen = 1'b1;
        free_idx_next      = IDX_W'(MY_IDX);
      end

      // Credit-all adds to any live non-faulty entry that stays <= max.
      if (tok_in.op == OP_CREDIT_ALL && valid && (c_all <= $signed({cfg.max_credit[CREDIT_W-1],
          cfg.max_credit})) && (rating != cfg.faulty_rating)) begin
        credit_next = sat_credit(c_all);
      end

      if (hit) begin
        tok_next.found = 1'b1;
        case (tok_in.op)
          OP_REMOVE: begin
            valid_next  = 1'b0;
            tok_next.ok = 1'b1;
          end
          OP_CREDIT_UP: begin
            if (c_up <= $signed({cfg.max_credit[CREDIT_W-1], cfg.max_credit})) begin
              credit_next = c_up[CREDIT_W-1:0];
              tok_next.ok = 1'b1;
            end
          end
          OP_CREDIT_DN: begin
            if (c_dn >= $signed({cfg.min_credit[CREDIT_W-1], cfg.min_credit})) begin
              credit_next = c_dn[CREDIT_W-1:0];
              tok_next.ok = 1'b1;
            end
          end
          OP_QUERY: begin
            tok_next.ok = 1'b1;
          end
          OP_RATING_SET: begin
            rating_next = sat_rating(v_ext);
            tok_next.ok = 1'b1;
          end
          OP_RATING_UP: begin
            if (r_up <= $signed({{(CREDIT_W + 1 - RATING_W){cfg.good_rating[RATING_W-1]}},
                cfg.good_rating})) begin
              rating_next = sat_rating(r_up);
              tok_next.ok = 1'b1;
            end
          end
          OP_RATING_DN: begin
            if (r_dn >= $signed({{(CREDIT_W + 1 - RATING_W){cfg.faulty_rating[RATING_W-1]}},
                cfg.faulty_rating})) begin
              rating_next = sat_rating(r_dn);
            end else begin
              rating_next = cfg.faulty_rating;
            end
            tok_next.ok = 1'b1;
          end
          default: begin
          end
        endcase
        tok_next.credit = credit_next;
        tok_next.rating = rating_next;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      tok_out_valid <= 1'b0;
    end else begin
      valid         <= valid_next;
      tok_out_valid <= tok_in_valid;
    end
  end

  // Entry contents and the outgoing command.
  always_ff @(posedge clk) begin
    key          <= key_next;
    credit       <= credit_next;
    rating       <= rating_next;
    tok_out      <= tok_next;
    key_out      <= key_in;
    free_idx_out <= free_idx_next;
  end

endmodule

// ===== rtl/core/credit_rating_table_core.sv =====
// Top level of the credit and rating table: request intake, cell row and result.
`timescale 1ns / 1ps

// Associative credit and rating table built as a row of NUM_ENTRIES cells, one
// slot per cell. An accepted request is registered, then walks down the row one
// cell per clock; each cell compares its key, applies the operation to its own
// entry and passes the command on with what it found. At the end of the row an
// add that found no match writes the lowest free slot at the same edge that
// stores the result. The result is stored once the command leaves the last cell
// and moves into the output register when the output is free. The next request
// is taken the cycle after the result has moved into the output register, so the
// table handles one request at a time. Keys are the low ADDR_BITS bits of the
// address, at most ADDR_W. Configuration must be written only while idle; the
// block itself does not enforce this.
module credit_rating_table_core import crt_pkg::*; #(
  parameter int NUM_ENTRIES = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CREDIT_W-1:0]   cfg_data
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int KEY_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

  cfg_t cfg;

  logic             tok_valid [0:NUM_ENTRIES];
  tok_t             tok       [0:NUM_ENTRIES];
  logic [KEY_W-1:0] tok_key   [0:NUM_ENTRIES];
  logic [IDX_W-1:0] tok_free  [0:NUM_ENTRIES];

  logic             busy;
  logic             done_valid;
  rsp_t             done;
  rsp_t             done_next;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [KEY_W-1:0] wr_key;
  logic             req_beat;
  logic             move;
  tok_t             tail;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_credit     <= RST_MAX_CREDIT;
      cfg.min_credit     <= RST_MIN_CREDIT;
      cfg.initial_credit <= RST_INITIAL_CREDIT;
      cfg.step_up        <= RST_STEP_UP;
      cfg.step_down      <= RST_STEP_DOWN;
      cfg.start_rating   <= RST_START_RATING;
      cfg.good_rating    <= RST_GOOD_RATING;
      cfg.faulty_rating  <= RST_FAULTY_RATING;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_CREDIT:     cfg.max_credit     <= cfg_data;
        REG_MIN_CREDIT:     cfg.min_credit     <= cfg_data;
        REG_INITIAL_CREDIT: cfg.initial_credit <= cfg_data;
        REG_STEP_UP:        cfg.step_up        <= cfg_data[STEP_W-1:0];
        REG_STEP_DOWN:      cfg.step_down      <= cfg_data[STEP_W-1:0];
        REG_START_RATING:   cfg.start_rating   <= cfg_data[RATING_W-1:0];
        REG_GOOD_RATING:    cfg.good_rating    <= cfg_data[RATING_W-1:0];
        REG_FAULTY_RATING:  cfg.faulty_rating  <= cfg_data[RATING_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // One request at a time; hold off while a sweep or a stored result is pending.
  assign req_stall = busy | done_valid;
  assign req_beat  = req_valid && !req_stall;

  // Launch register at the head of the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid[0] <= 1'b0;
    end else begin
      tok_valid[0] <= req_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (req_beat) begin
      tok[0].op        <= req.op;
      tok[0].value     <= req.value;
      tok[0].found     <= 1'b0;
      tok[0].ok        <= 1'b0;
      tok[0].free_seen <= 1'b0;
      tok[0].credit    <= CREDIT_ABSENT;
      tok[0].rating    <= RATING_ABSENT;
      tok_key[0]       <= req.address[KEY_W-1:0];
      tok_free[0]      <= '0;
    end
  end

  // The row of table cells.
  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    crt_cell #(
      .IDX_W  (IDX_W),
      .KEY_W  (KEY_W),
      .MY_IDX (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cfg           (cfg),
      .tok_in_valid  (tok_valid[i]),
      .tok_in        (tok[i]),
      .key_in        (tok_key[i]),
      .free_idx_in   (tok_free[i]),
      .wr_en         (wr_en),
      .wr_idx        (wr_idx),
      .wr_key        (wr_key),
      .tok_out_valid (tok_valid[i+1]),
      .tok_out       (tok[i+1]),
      .key_out       (tok_key[i+1]),
      .free_idx_out  (tok_free[i+1])
    );
  end

  assign tail = tok[NUM_ENTRIES];

  // Wrap-up at the end of the row: place a new entry and form the result.
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = tok_free[NUM_ENTRIES];
    wr_key = tok_key[NUM_ENTRIES];

    done_next.ok      = tail.ok;
    done_next.present = tail.found;
    done_next.credit  = tail.found ? tail.credit : CREDIT_ABSENT;
    done_next.rating  = tail.found ? tail.rating : RATING_ABSENT;

    case (tail.op)
      OP_ADD: begin
        if (!tail.found && tail.free_seen) begin
          wr_en             = tok_valid[NUM_ENTRIES];
          done_next.ok      = 1'b1;
          done_next.present = 1'b1;
          done_next.credit  = cfg.initial_credit;
          done_next.rating  = cfg.start_rating;
        end else begin
          done_next.ok = 1'b0;
        end
      end
      OP_REMOVE: begin
        done_next.present = 1'b0;
        done_next.credit  = CREDIT_ABSENT;
        done_next.rating  = RATING_ABSENT;
      end
      OP_CREDIT_ALL: begin
        done_next.ok = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sweep tracking and the stored result.
  assign move = done_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_beat) begin
        busy <= 1'b1;
      end else if (tok_valid[NUM_ENTRIES]) begin
        busy <= 1'b0;
      end

      if (tok_valid[NUM_ENTRIES]) begin
        done_valid <= 1'b1;
      end else if (move) begin
        done_valid <= 1'b0;
      end

      if (move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid[NUM_ENTRIES]) begin
      done <= done_next;
    end
    if (move) begin
      rsp <= done;
    end
  end

endmodule

// ===== test/tb_credit_rating_table_core.sv =====
// Self-checking testbench for the credit and rating table core.
`timescale 1ns / 1ps

module tb_credit_rating_table_core;
  import crt_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int POOL_SIZE   = 24;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_kind_e;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CREDIT_W-1:0]  cfg_data = '0;

  credit_rating_table_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Commands waiting to be sent, and the results the table should give back.
  req_t cmd_queue[$];
  rsp_t predicted[$];
  int   err_count = 0;
  int   cycle_count = 0;

  // Shadow copy of the table and its limits.
  logic        slot_used [TABLE_SLOTS];
  logic [15:0] slot_key [TABLE_SLOTS];
  int          slot_credit [TABLE_SLOTS];
  int          slot_rating [TABLE_SLOTS];
  int          lim_max_credit;
  int          lim_min_credit;
  int          lim_init_credit;
  int          lim_step_up;
  int          lim_step_down;
  int          lim_init_rating;
  int          lim_good_rating;
  int          lim_faulty_rating;

  logic [15:0] addr_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    err_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int bound(input int x, input int lo, input int hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Apply one command to the shadow table and return the result it must produce.
  function automatic rsp_t table_apply(input req_t r);
    int   slot;
    int   v;
    int   sum;
    logic ok_f;
    rsp_t res;
    slot = -1;
    ok_f = 1'b0;
    v = int'($signed(r.value));
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (slot < 0 && slot_used[i] && slot_key[i] == r.address) begin
        slot = i;
      end
    end
    case (r.op)
      OP_ADD: begin
        if (slot < 0) begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot < 0 && !slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_key[i] = r.address;
              slot_credit[i] = lim_init_credit;
              slot_rating[i] = lim_init_rating;
              slot = i;
              ok_f = 1'b1;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (slot >= 0) begin
          slot_used[slot] = 1'b0;
          slot = -1;
          ok_f = 1'b1;
        end
      end
      OP_CREDIT_UP: begin
        if (slot >= 0 && slot_credit[slot] + lim_step_up <= lim_max_credit) begin
          slot_credit[slot] += lim_step_up;
          ok_f = 1'b1;
        end
      end
      OP_CREDIT_DN: begin
        if (slot >= 0 && slot_credit[slot] - lim_step_down >= lim_min_credit) begin
          slot_credit[slot] -= lim_step_down;
          ok_f = 1'b1;
        end
      end
      OP_QUERY: begin
        ok_f = (slot >= 0);
      end
      OP_CREDIT_ALL: begin
        // Live entries not rated faulty take the amount unless the sum passes the cap.
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          sum = slot_credit[i] + v;
          if (slot_used[i] && sum <= lim_max_credit && slot_rating[i] != lim_faulty_rating) begin
            slot_credit[i] = bound(sum, -32768, 32767);
          end
        end
        ok_f = 1'b1;
      end
      OP_RATING_SET: begin
        if (slot >= 0) begin
          slot_rating[slot] = bound(v, -128, 127);
          ok_f = 1'b1;
        end
      end
      OP_RATING_UP: begin
        if (slot >= 0 && slot_rating[slot] + v <= lim_good_rating) begin
          slot_rating[slot] = bound(slot_rating[slot] + v, -128, 127);
          ok_f = 1'b1;
        end
      end
      OP_RATING_DN: begin
        if (slot >= 0) begin
          if (slot_rating[slot] - v >= lim_faulty_rating) begin
            slot_rating[slot] = bound(slot_rating[slot] - v, -128, 127);
          end else begin
            slot_rating[slot] = lim_faulty_rating;
          end
          ok_f = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.ok = ok_f;
    if (slot >= 0) begin
      res.present = 1'b1;
      res.credit = 16'(slot_credit[slot]);
      res.rating = 8'(slot_rating[slot]);
    end else begin
      res.present = 1'b0;
      res.credit = CREDIT_ABSENT;
      res.rating = RATING_ABSENT;
    end
    return res;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!req_valid || !req_stall) begin
      if (gap_left > 0) begin
        req_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
        req <= cmd_queue.pop_front();
        req_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          if ($urandom_range(0, 3) == 0) begin
            gap_left <= 0;
          end else begin
            gap_left <= $urandom_range(1, ($urandom_range(0, 4) == 0) ? 24 : 5);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall behavior switches among a few patterns of random duration.
  stall_kind_e stall_kind = STALL_NONE;
  int          kind_left = 0;
  int          kind_phase = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_kind <= STALL_NONE;
      kind_left <= 0;
      kind_phase <= 0;
    end else begin
      if (kind_left == 0) begin
        stall_kind <= stall_kind_e'($urandom_range(0, 2));
        kind_left <= $urandom_range(20, 300);
        kind_phase <= 0;
      end else begin
        kind_left <= kind_left - 1;
        kind_phase <= kind_phase + 1;
      end
      case (stall_kind)
        STALL_NONE:   rsp_stall <= 1'b0;
        STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
        default:      rsp_stall <= ((kind_phase % 9) < 5);
      endcase
    end
  end

  // Predict on every accepted command beat and check every accepted result beat.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predicted.push_back(table_apply(req));
      end
      if (rsp_valid && !rsp_stall) begin
        if (predicted.size() == 0) begin
          flag_error("result beat with nothing expected");
        end else begin
          want = predicted.pop_front();
          if (rsp.ok !== want.ok) begin
            flag_error($sformatf("ok got %b want %b", rsp.ok, want.ok));
          end
          if (rsp.present !== want.present) begin
            flag_error($sformatf("present got %b want %b", rsp.present, want.present));
          end
          if (rsp.credit !== want.credit) begin
            flag_error($sformatf("credit got %0d want %0d", rsp.credit, want.credit));
          end
          if (rsp.rating !== want.rating) begin
            flag_error($sformatf("rating got %0d want %0d", rsp.rating, want.rating));
          end
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL credit_rating_table_core");
      $finish;
    end
  end

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [15:0] addr,
                          input logic [15:0] val);
    req_t r;
    r.op = op;
    r.address = addr;
    r.value = val;
    cmd_queue.push_back(r);
  endtask

  // Amounts are mostly small so that bounds are met, with extremes and full-range noise.
  function automatic logic [15:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      return 16'($urandom_range(0, 40) - 20);
    end else if (sel == 6) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic push_random(input int count);
    logic [OP_W-1:0] op;
    logic [15:0]     addr;
    int              w;
    for (int n = 0; n < count; n++) begin
      w = $urandom_range(0, 99);
      if (w < 22) op = OP_ADD;
      else if (w < 32) op = OP_REMOVE;
      else if (w < 44) op = OP_CREDIT_UP;
      else if (w < 54) op = OP_CREDIT_DN;
      else if (w < 63) op = OP_QUERY;
      else if (w < 70) op = OP_CREDIT_ALL;
      else if (w < 78) op = OP_RATING_SET;
      else if (w < 86) op = OP_RATING_UP;
      else if (w < 94) op = OP_RATING_DN;
      else op = 4'($urandom_range(OP_RATING_DN + 1, 15));
      if ($urandom_range(0, 99) < 85) begin
        addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        addr = 16'($urandom);
      end
      push_cmd(op, addr, pick_value());
    end
  endtask

  // Drive one register write and track it in the shadow limits.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_MAX_CREDIT:     lim_max_credit = int'($signed(data));
      REG_MIN_CREDIT:     lim_min_credit = int'($signed(data));
      REG_INITIAL_CREDIT: lim_init_credit = int'($signed(data));
      REG_STEP_UP:        lim_step_up = int'(data[14:0]);
      REG_STEP_DOWN:      lim_step_down = int'(data[14:0]);
      REG_START_RATING:   lim_init_rating = int'($signed(data[7:0]));
      REG_GOOD_RATING:    lim_good_rating = int'($signed(data[7:0]));
      default:            lim_faulty_rating = int'($signed(data[7:0]));
    endcase
  endtask

  task automatic set_limits(input logic [15:0] mx, input logic [15:0] mn,
                            input logic [15:0] ic, input logic [15:0] su,
                            input logic [15:0] sd, input logic [15:0] ir,
                            input logic [15:0] gr, input logic [15:0] fr);
    write_reg(REG_MAX_CREDIT, mx);
    write_reg(REG_MIN_CREDIT, mn);
    write_reg(REG_INITIAL_CREDIT, ic);
    write_reg(REG_STEP_UP, su);
    write_reg(REG_STEP_DOWN, sd);
    write_reg(REG_START_RATING, ir);
    write_reg(REG_GOOD_RATING, gr);
    write_reg(REG_FAULTY_RATING, fr);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every command is sent and answered, then let the core settle.
  task automatic wait_quiet(input int settle);
    do @(negedge clk);
    while (cmd_queue.size() != 0 || predicted.size() != 0 || req_valid);
    repeat (settle) @(negedge clk);
  endtask

  // Random limits in a modest range; rating writes carry noise in the unused byte.
  task automatic random_limits();
    int mx;
    int mn;
    mx = $urandom_range(0, 300);
    mn = -$urandom_range(0, 300);
    set_limits(16'(mx), 16'(mn), 16'($urandom_range(0, mx - mn) + mn),
               16'($urandom_range(0, 40)), {1'($urandom), 15'($urandom_range(0, 40))},
               {8'($urandom), 8'($urandom_range(0, 80) - 40)},
               {8'($urandom), 8'($urandom_range(0, 40))},
               {8'($urandom), 8'(-$urandom_range(0, 40))});
  endtask

  initial begin
    lim_max_credit = int'(RST_MAX_CREDIT);
    lim_min_credit = int'(RST_MIN_CREDIT);
    lim_init_credit = int'(RST_INITIAL_CREDIT);
    lim_step_up = int'(RST_STEP_UP);
    lim_step_down = int'(RST_STEP_DOWN);
    lim_init_rating = int'(RST_START_RATING);
    lim_good_rating = int'(RST_GOOD_RATING);
    lim_faulty_rating = int'(RST_FAULTY_RATING);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_credit[i] = 0;
      slot_rating[i] = 0;
    end

    // Address pool: corner keys, random keys, and near misses one bit away.
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    addr_pool[2] = 16'h8000;
    addr_pool[3] = 16'h0001;
    addr_pool[4] = 16'h7FFF;
    for (int i = 5; i < 14; i++) addr_pool[i] = 16'($urandom);
    for (int i = 14; i < POOL_SIZE; i++) begin
      addr_pool[i] = addr_pool[$urandom_range(0, 13)] ^ (16'h1 << $urandom_range(0, 15));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under reset limits: absent entries, duplicates, saturation,
    // faulty clamping, the faulty skip in credit-all and undefined codes.
    push_cmd(OP_QUERY, 16'h0000, 16'h0000);
    push_cmd(OP_REMOVE, 16'h1234, 16'h0000);
    push_cmd(OP_CREDIT_UP, 16'hFFFF, 16'h0000);
    push_cmd(OP_ADD, 16'h0000, 16'h0000);
    push_cmd(OP_ADD, 16'h0000, 16'h0000);
    push_cmd(OP_ADD, 16'hFFFF, 16'hFFFF);
    push_cmd(OP_CREDIT_UP, 16'hFFFF, 16'h0000);
    push_cmd(OP_CREDIT_DN, 16'h0000, 16'h0000);
    push_cmd(OP_RATING_SET, 16'hFFFF, 16'h7FFF);
    push_cmd(OP_RATING_SET, 16'h0000, 16'h8000);
    push_cmd(OP_RATING_UP, 16'h0000, 16'h0005);
    push_cmd(OP_RATING_UP, 16'hFFFF, 16'h0001);
    push_cmd(OP_RATING_DN, 16'hFFFF, 16'h8000);
    push_cmd(OP_RATING_DN, 16'h0000, 16'h7FFF);
    push_cmd(OP_CREDIT_ALL, 16'hFFFF, 16'h0032);
    push_cmd(OP_CREDIT_ALL, 16'h0000, 16'h8000);
    push_cmd(OP_CREDIT_ALL, 16'hFFFF, 16'h8000);
    push_cmd(OP_CREDIT_DN, 16'hFFFF, 16'h0000);
    push_cmd(OP_CREDIT_ALL, 16'h0001, 16'h7FFF);
    push_cmd(4'd9, 16'hFFFF, 16'h1111);
    push_cmd(4'd15, 16'h0000, 16'hEEEE);
    push_cmd(OP_REMOVE, 16'hFFFF, 16'h0000);
    push_cmd(OP_QUERY, 16'hFFFF, 16'h0000);
    push_cmd(OP_RATING_DN, 16'hFFFF, 16'h0001);
    wait_quiet(8);

    set_limits(16'd200, -16'sd50, 16'd0, 16'd7, 16'd5, 16'd3, 16'd20, -16'sd20);
    push_random(200);
    wait_quiet(8);

    // Widest limits: full-range credits and steps, ratings at their ends.
    set_limits(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hA580,
               16'h007F, 16'h0080);
    push_random(150);
    wait_quiet(8);

    // Inverted limits with zero steps.
    set_limits(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h007F,
               16'h0080, 16'h5A7F);
    push_random(75);
    wait_quiet(8);

    random_limits();
    push_random(100);
    wait_quiet(8);

    random_limits();
    push_random(100);
    wait_quiet(DRAIN_WAIT);

    if (predicted.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", predicted.size()));
    end
    if (err_count == 0) begin
      $display("PASS credit_rating_table_core");
    end else begin
      $display("FAIL credit_rating_table_core");
    end
    $finish;
  end

endmodule
